// ===== rtl/plbk_pkg.sv =====
// shared types, constants and codes of the price level order book
package plbk_pkg;

    localparam int MAX_ORDERS = 1024;
    localparam int MAX_LEVELS = 256;
    localparam int ORDER_AW = $clog2(MAX_ORDERS);
    localparam int LEVEL_CW = $clog2(MAX_LEVELS) + 1;
    localparam int TOTAL_W = 42;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // event codes
    localparam logic [1:0] FN_ADD = 2'd0;
    localparam logic [1:0] FN_CANCEL = 2'd1;
    localparam logic [1:0] FN_MODIFY = 2'd2;
    localparam logic [1:0] FN_EXEC = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // level chain operations
    localparam logic [2:0] LOP_IDLE = 3'd0;
    localparam logic [2:0] LOP_CLR = 3'd1;
    localparam logic [2:0] LOP_SCAN = 3'd2;
    localparam logic [2:0] LOP_ADD = 3'd3;
    localparam logic [2:0] LOP_SUB = 3'd4;
    localparam logic [2:0] LOP_WAVE = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic        is_ask;
        logic [31:0] limit;
        logic [31:0] remaining;
    } order_entry_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        price;
        logic [TOTAL_W-1:0] qty;
        logic               found;
    } lvl_cmd_t;

    typedef struct packed {
        logic        found;
        logic        full;
        logic [31:0] best;
    } lvl_stat_t;

    // travels from a cell to its right neighbor
    typedef struct packed {
        logic               ahead;
        logic               fnd;
        logic               cv;
        logic [31:0]        cprice;
        logic [TOTAL_W-1:0] ctotal;
        logic               hole;
    } lvl_fwd_t;

    // travels from a cell to its left neighbor
    typedef struct packed {
        logic               vld;
        logic [31:0]        price;
        logic [TOTAL_W-1:0] total;
    } lvl_back_t;

endpackage

// ===== rtl/plbk_level_cell.sv =====
// one price level cell of a sorted level chain
module plbk_level_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              is_ask,
    input  plbk_pkg::lvl_cmd_t  cmd,
    input  plbk_pkg::lvl_fwd_t  left,
    input  plbk_pkg::lvl_back_t right,
    output plbk_pkg::lvl_fwd_t  fwd,
    output plbk_pkg::lvl_back_t back
);
    import plbk_pkg::*;

    logic               vld_reg, vld_next;
    logic               fnd_reg, fnd_next;
    logic               cv_reg, cv_next;
    logic               hole_reg, hole_next;
    logic [31:0]        price_reg, price_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [31:0]        cprice_reg, cprice_next;
    logic [TOTAL_W-1:0] ctotal_reg, ctotal_next;
    logic               match;
    logic               ahead;
    logic [TOTAL_W:0]   sum;

    assign match = vld_reg && (price_reg == cmd.price);
    assign ahead = !vld_reg || (is_ask ? (price_reg > cmd.price) : (price_reg < cmd.price));
    assign sum = {1'b0, total_reg} + {1'b0, cmd.qty};

    always_comb
    begin
        vld_next = vld_reg;
        fnd_next = fnd_reg;
        cv_next = cv_reg;
        hole_next = hole_reg;
        price_next = price_reg;
        total_next = total_reg;
        cprice_next = cprice_reg;
        ctotal_next = ctotal_reg;
        case (cmd.op)
            LOP_CLR:
            begin
                fnd_next = 1'b0;
                cv_next = 1'b0;
                hole_next = 1'b0;
            end
            LOP_SCAN:
            begin
                fnd_next = match || left.fnd;
            end
            LOP_ADD:
            begin
                if (match)
                begin
                    total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                end
                else if (ahead && !left.ahead && !cmd.found)
                begin
                    // new level lands here, old content starts moving right
                    cv_next = vld_reg;
                    cprice_next = price_reg;
                    ctotal_next = total_reg;
                    vld_next = 1'b1;
                    price_next = cmd.price;
                    total_next = cmd.qty;
                end
            end
            LOP_SUB:
            begin
                if (match)
                begin
                    if (total_reg <= cmd.qty)
                    begin
                        hole_next = 1'b1;
                    end
                    else
                    begin
                        total_next = total_reg - cmd.qty;
                    end
                end
            end
            LOP_WAVE:
            begin
                // hole closes leftward, carry moves rightward
                hole_next = left.hole && vld_reg;
                if (hole_reg)
                begin
                    if (right.vld)
                    begin
                        price_next = right.price;
                        total_next = right.total;
                    end
                    else
                    begin
                        vld_next = 1'b0;
                    end
                end
                if (left.cv)
                begin
                    cv_next = vld_reg;
                    cprice_next = price_reg;
                    ctotal_next = total_reg;
                    vld_next = 1'b1;
                    price_next = left.cprice;
                    total_next = left.ctotal;
                end
                else
                begin
                    cv_next = 1'b0;
                end
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            fnd_reg <= 1'b0;
            cv_reg <= 1'b0;
            hole_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            fnd_reg <= fnd_next;
            cv_reg <= cv_next;
            hole_reg <= hole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        total_reg <= total_next;
        cprice_reg <= cprice_next;
        ctotal_reg <= ctotal_next;
    end

    assign fwd.ahead = ahead;
    assign fwd.fnd = fnd_reg;
    assign fwd.cv = cv_reg;
    assign fwd.cprice = cprice_reg;
    assign fwd.ctotal = ctotal_reg;
    assign fwd.hole = hole_reg;
    assign back.vld = vld_reg;
    assign back.price = price_reg;
    assign back.total = total_reg;

endmodule

// ===== rtl/plbk_level_side.sv =====
// sorted chain of level cells for one side of the book
module plbk_level_side (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               is_ask,
    input  plbk_pkg::lvl_cmd_t   cmd,
    output plbk_pkg::lvl_stat_t  stat
);
    import plbk_pkg::*;

    lvl_fwd_t  fwd [MAX_LEVELS];
    lvl_back_t back [MAX_LEVELS];

    genvar g;
    generate
        for (g = 0; g < MAX_LEVELS; g++)
        begin : g_cell
            lvl_fwd_t  l_in;
            lvl_back_t r_in;
            if (g == 0)
            begin : g_first
                assign l_in = '0;
            end
            else
            begin : g_mid
                assign l_in = fwd[g-1];
            end
            if (g == MAX_LEVELS - 1)
            begin : g_last
                assign r_in = '0;
            end
            else
            begin : g_inner
                assign r_in = back[g+1];
            end
            plbk_level_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .is_ask (is_ask),
                .cmd    (cmd),
                .left   (l_in),
                .right  (r_in),
                .fwd    (fwd[g]),
                .back   (back[g])
            );
        end
    endgenerate

    assign stat.found = fwd[MAX_LEVELS-1].fnd;
    assign stat.full = back[MAX_LEVELS-1].vld;
    assign stat.best = back[0].vld ? back[0].price : 32'd0;

endmodule

// ===== rtl/price_level_order_book.sv =====
// price level order book top level: order table, sequencer and two level chains
//
// one event at a time: an event is taken when start is high and busy is low,
// and its result shows on rsp for exactly one cycle with done high; the
// receiver cannot stall, so it must take every result in that cycle. the
// order table is a single port memory scanned one entry a cycle for the id
// and the lowest free slot, then the level chain runs a match sweep and a
// shift sweep. after reset the block runs a clearing pass over the order
// table with busy high before it takes the first event.
module price_level_order_book (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  plbk_pkg::req_t  req,
    output logic            busy,
    output logic            done,
    output plbk_pkg::rsp_t  rsp
);
    import plbk_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LCLR = 3'd3;
    localparam logic [2:0] S_LSCAN = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_APPLY = 3'd6;
    localparam logic [2:0] S_WAVE = 3'd7;
    localparam logic [2:0] S_RESP_UNUSED = 3'd7;

    // order table memory
    order_entry_t order_mem [MAX_ORDERS];
    order_entry_t mem_rdata_reg;
    logic [ORDER_AW-1:0] mem_addr;
    logic         mem_we;
    order_entry_t mem_wdata;

    logic [2:0]          state_reg, state_next;
    logic                resp_reg, resp_next;
    logic [ORDER_AW:0]   cnt_reg, cnt_next;
    logic [LEVEL_CW-1:0] lcnt_reg, lcnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [ORDER_AW-1:0] rd_idx_reg, rd_idx_next;
    logic                hit_reg, hit_next;
    logic                free_reg, free_next;

    req_t                req_reg, req_next;
    logic [ORDER_AW-1:0] hit_idx_reg, hit_idx_next;
    order_entry_t        hit_ent_reg, hit_ent_next;
    logic [ORDER_AW-1:0] free_idx_reg, free_idx_next;
    logic [1:0]          status_reg, status_next;
    logic [2:0]          lop_reg, lop_next;
    logic [TOTAL_W-1:0]  lq_reg, lq_next;
    logic                wr_en_reg, wr_en_next;
    logic [ORDER_AW-1:0] wr_idx_reg, wr_idx_next;
    order_entry_t        wr_word_reg, wr_word_next;

    lvl_cmd_t  bid_cmd, ask_cmd, sel_cmd;
    lvl_stat_t bid_stat, ask_stat, sel_stat;
    logic      side_sel;
    logic [31:0] qty;
    logic [31:0] old;
    logic [31:0] traded;

    assign side_sel = (req_reg.func == FN_ADD) ? req_reg.side : hit_ent_reg.is_ask;
    assign sel_stat = side_sel ? ask_stat : bid_stat;
    assign qty = req_reg.quantity;
    assign old = hit_ent_reg.remaining;
    assign traded = (qty < old) ? qty : old;

    // memory port: clear pass, scan reads, at most one write per event
    always_comb
    begin
        mem_addr = '0;
        mem_we = 1'b0;
        mem_wdata = wr_word_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_addr = cnt_reg[ORDER_AW-1:0];
                mem_we = 1'b1;
                mem_wdata = '0;
            end
            S_SCAN:
            begin
                mem_addr = cnt_reg[ORDER_AW-1:0];
            end
            S_APPLY:
            begin
                mem_addr = wr_idx_reg;
                mem_we = wr_en_reg;
            end
            default:
            begin
                mem_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            order_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= order_mem[mem_addr];
    end

    // level chain commands go to the side concerned only
    always_comb
    begin
        sel_cmd.price = (req_reg.func == FN_ADD) ? req_reg.price : hit_ent_reg.limit;
        sel_cmd.qty = lq_reg;
        sel_cmd.found = sel_stat.found;
        case (state_reg)
            S_LCLR:  sel_cmd.op = LOP_CLR;
            S_LSCAN: sel_cmd.op = LOP_SCAN;
            S_APPLY: sel_cmd.op = lop_reg;
            S_WAVE:  sel_cmd.op = resp_reg ? LOP_IDLE : LOP_WAVE;
            default: sel_cmd.op = LOP_IDLE;
        endcase
        bid_cmd = sel_cmd;
        ask_cmd = sel_cmd;
        if (side_sel)
        begin
            bid_cmd.op = LOP_IDLE;
        end
        else
        begin
            ask_cmd.op = LOP_IDLE;
        end
    end

    plbk_level_side u_bid (
        .clk    (clk),
        .rst_n  (rst_n),
        .is_ask (1'b0),
        .cmd    (bid_cmd),
        .stat   (bid_stat)
    );

    plbk_level_side u_ask (
        .clk    (clk),
        .rst_n  (rst_n),
        .is_ask (1'b1),
        .cmd    (ask_cmd),
        .stat   (ask_stat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        resp_next = 1'b0;
        cnt_next = cnt_reg;
        lcnt_next = lcnt_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        hit_next = hit_reg;
        free_next = free_reg;
        req_next = req_reg;
        hit_idx_next = hit_idx_reg;
        hit_ent_next = hit_ent_reg;
        free_idx_next = free_idx_reg;
        status_next = status_reg;
        lop_next = lop_reg;
        lq_next = lq_reg;
        wr_en_next = wr_en_reg;
        wr_idx_next = wr_idx_reg;
        wr_word_next = wr_word_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (ORDER_AW+1)'(MAX_ORDERS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    free_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one read a cycle, check the one that came back
                if (cnt_reg != (ORDER_AW+1)'(MAX_ORDERS))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[ORDER_AW-1:0];
                end
                if (rd_vld_reg)
                begin
                    if (mem_rdata_reg.valid && mem_rdata_reg.key == req_reg.order_id && !hit_reg)
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        hit_ent_next = mem_rdata_reg;
                    end
                    if (!mem_rdata_reg.valid && !free_reg)
                    begin
                        free_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == ORDER_AW'(MAX_ORDERS - 1))
                    begin
                        state_next = S_LCLR;
                    end
                end
                lq_next = '0;
            end
            S_LCLR:
            begin
                lcnt_next = '0;
                state_next = S_LSCAN;
            end
            S_LSCAN:
            begin
                lcnt_next = lcnt_reg + 1'b1;
                if (lcnt_reg == LEVEL_CW'(MAX_LEVELS - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                status_next = ST_OK;
                lop_next = LOP_IDLE;
                lq_next = '0;
                wr_en_next = 1'b0;
                wr_idx_next = hit_idx_reg;
                wr_word_next = hit_ent_reg;
                if (req_reg.func == FN_ADD)
                begin
                    if (hit_reg)
                    begin
                        status_next = ST_DUPLICATE;
                    end
                    else if (!free_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (qty != 32'd0 && !sel_stat.found && sel_stat.full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en_next = 1'b1;
                        wr_idx_next = free_idx_reg;
                        wr_word_next.valid = 1'b1;
                        wr_word_next.key = req_reg.order_id;
                        wr_word_next.is_ask = req_reg.side;
                        wr_word_next.limit = req_reg.price;
                        wr_word_next.remaining = qty;
                        if (qty != 32'd0)
                        begin
                            lop_next = LOP_ADD;
                            lq_next = TOTAL_W'(qty);
                        end
                    end
                end
                else if (!hit_reg)
                begin
                    status_next = ST_UNKNOWN;
                end
                else
                begin
                    case (req_reg.func)
                        FN_CANCEL:
                        begin
                            lop_next = LOP_SUB;
                            lq_next = TOTAL_W'(old);
                            wr_en_next = 1'b1;
                            wr_word_next.valid = 1'b0;
                        end
                        FN_MODIFY:
                        begin
                            if (qty > old)
                            begin
                                if (!sel_stat.found && sel_stat.full)
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    lop_next = LOP_ADD;
                                    lq_next = TOTAL_W'(qty - old);
                                    wr_en_next = 1'b1;
                                    wr_word_next.remaining = qty;
                                end
                            end
                            else
                            begin
                                lop_next = LOP_SUB;
                                lq_next = TOTAL_W'(old - qty);
                                wr_en_next = 1'b1;
                                wr_word_next.remaining = qty;
                            end
                        end
                        default:
                        begin
                            // execute
                            lop_next = LOP_SUB;
                            lq_next = TOTAL_W'(traded);
                            wr_en_next = 1'b1;
                            wr_word_next.remaining = old - traded;
                            wr_word_next.valid = (old != traded);
                        end
                    endcase
                end
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                lcnt_next = '0;
                state_next = S_WAVE;
            end
            default:
            begin
                // shift sweep, then one result cycle
                if (resp_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lcnt_next = lcnt_reg + 1'b1;
                    if (lcnt_reg == LEVEL_CW'(MAX_LEVELS - 1))
                    begin
                        resp_next = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            resp_reg <= 1'b0;
            cnt_reg <= '0;
            lcnt_reg <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg <= resp_next;
            cnt_reg <= cnt_next;
            lcnt_reg <= lcnt_next;
            rd_vld_reg <= rd_vld_next;
            hit_reg <= hit_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rd_idx_reg <= rd_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_ent_reg <= hit_ent_next;
        free_idx_reg <= free_idx_next;
        status_reg <= status_next;
        lop_reg <= lop_next;
        lq_reg <= lq_next;
        wr_en_reg <= wr_en_next;
        wr_idx_reg <= wr_idx_next;
        wr_word_reg <= wr_word_next;
    end

    // result transfer: one cycle at the end of the shift sweep
    assign busy = (state_reg != S_IDLE);
    assign done = resp_reg && (state_reg == S_RESP_UNUSED);
    assign rsp.status = status_reg;
    assign rsp.best_bid = bid_stat.best;
    assign rsp.best_ask = ask_stat.best;

    // a result is always followed by the idle state
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after a result");

    // a taken event keeps the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("event taken without going busy");

    // duplicate id only comes from an add
    a_dup_add: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_DUPLICATE) |-> (req_reg.func == FN_ADD))
        else $error("duplicate status on a non add event");

    // unknown id never comes from an add
    a_unknown_not_add: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_UNKNOWN) |-> (req_reg.func != FN_ADD))
        else $error("unknown status on an add event");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the price level order book with its own book predictor
`timescale 1ns / 100ps

module tb;
    import plbk_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    price_level_order_book dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predicted copy of the book
    bit                 book_live [MAX_ORDERS];
    logic [31:0]        book_id   [MAX_ORDERS];
    bit                 book_ask  [MAX_ORDERS];
    logic [31:0]        book_px   [MAX_ORDERS];
    logic [31:0]        book_qty  [MAX_ORDERS];
    logic [31:0]        ladder_px [2][MAX_LEVELS];
    logic [TOTAL_W-1:0] ladder_tot[2][MAX_LEVELS];
    int                 ladder_n  [2];

    rsp_t pending_rsp[$];
    int   mismatches;
    int   results_seen;

    // ladder position of a price; bids descend, asks ascend
    function automatic bit ladder_find(input bit a, input logic [31:0] p, output int pos);
        int i;
        for (i = 0; i < ladder_n[a]; i++)
        begin
            if (ladder_px[a][i] == p)
            begin
                pos = i;
                return 1'b1;
            end
            if (a ? (ladder_px[a][i] > p) : (ladder_px[a][i] < p))
                break;
        end
        pos = i;
        return 1'b0;
    endfunction

    // a new level would be needed but the ladder is full
    function automatic bit ladder_blocked(input bit a, input logic [31:0] p,
                                          input logic [TOTAL_W-1:0] q);
        int pos;
        if (q == 0 || ladder_find(a, p, pos))
            return 1'b0;
        return ladder_n[a] >= MAX_LEVELS;
    endfunction

    function automatic void ladder_add(input bit a, input logic [31:0] p,
                                       input logic [TOTAL_W-1:0] q);
        int pos;
        logic [TOTAL_W:0] sum;
        if (q == 0)
            return;
        if (ladder_find(a, p, pos))
        begin
            sum = {1'b0, ladder_tot[a][pos]} + {1'b0, q};
            ladder_tot[a][pos] = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            return;
        end
        if (ladder_n[a] >= MAX_LEVELS)
            return;
        for (int i = ladder_n[a]; i > pos; i--)
        begin
            ladder_px[a][i] = ladder_px[a][i-1];
            ladder_tot[a][i] = ladder_tot[a][i-1];
        end
        ladder_px[a][pos] = p;
        ladder_tot[a][pos] = q;
        ladder_n[a]++;
    endfunction

    function automatic void ladder_sub(input bit a, input logic [31:0] p,
                                       input logic [TOTAL_W-1:0] q);
        int pos;
        if (!ladder_find(a, p, pos))
            return;
        if (ladder_tot[a][pos] <= q)
        begin
            for (int i = pos; i + 1 < ladder_n[a]; i++)
            begin
                ladder_px[a][i] = ladder_px[a][i+1];
                ladder_tot[a][i] = ladder_tot[a][i+1];
            end
            ladder_n[a]--;
        end
        else
            ladder_tot[a][pos] = ladder_tot[a][pos] - q;
    endfunction

    // apply one event to the predicted book and return its response
    function automatic rsp_t book_apply(input req_t r);
        rsp_t o;
        int idx;
        int slot;
        logic [31:0] traded;
        idx = -1;
        slot = -1;
        o.status = ST_OK;
        for (int i = 0; i < MAX_ORDERS; i++)
            if (book_live[i] && book_id[i] == r.order_id)
            begin
                idx = i;
                break;
            end
        if (r.func == FN_ADD)
        begin
            if (idx >= 0)
                o.status = ST_DUPLICATE;
            else
            begin
                for (int i = 0; i < MAX_ORDERS; i++)
                    if (!book_live[i])
                    begin
                        slot = i;
                        break;
                    end
                if (slot < 0 || ladder_blocked(r.side, r.price, TOTAL_W'(r.quantity)))
                    o.status = ST_FULL;
                else
                begin
                    ladder_add(r.side, r.price, TOTAL_W'(r.quantity));
                    book_live[slot] = 1'b1;
                    book_id[slot] = r.order_id;
                    book_ask[slot] = r.side;
                    book_px[slot] = r.price;
                    book_qty[slot] = r.quantity;
                end
            end
        end
        else if (idx < 0)
            o.status = ST_UNKNOWN;
        else if (r.func == FN_CANCEL)
        begin
            ladder_sub(book_ask[idx], book_px[idx], TOTAL_W'(book_qty[idx]));
            book_live[idx] = 1'b0;
        end
        else if (r.func == FN_MODIFY)
        begin
            if (r.quantity > book_qty[idx])
            begin
                if (ladder_blocked(book_ask[idx], book_px[idx],
                                   TOTAL_W'(r.quantity - book_qty[idx])))
                    o.status = ST_FULL;
                else
                begin
                    ladder_add(book_ask[idx], book_px[idx],
                               TOTAL_W'(r.quantity - book_qty[idx]));
                    book_qty[idx] = r.quantity;
                end
            end
            else
            begin
                ladder_sub(book_ask[idx], book_px[idx], TOTAL_W'(book_qty[idx] - r.quantity));
                book_qty[idx] = r.quantity;
            end
        end
        else
        begin
            traded = (r.quantity < book_qty[idx]) ? r.quantity : book_qty[idx];
            ladder_sub(book_ask[idx], book_px[idx], TOTAL_W'(traded));
            book_qty[idx] = book_qty[idx] - traded;
            if (book_qty[idx] == 0)
                book_live[idx] = 1'b0;
        end
        o.best_bid = ladder_n[0] != 0 ? ladder_px[0][0] : 32'd0;
        o.best_ask = ladder_n[1] != 0 ? ladder_px[1][0] : 32'd0;
        return o;
    endfunction

    // one event transfer: idle gap, then hold start until the block takes it
    task automatic send_event(input logic [1:0] f, input logic [31:0] id, input bit s,
                              input logic [31:0] p, input logic [31:0] q);
        int roll;
        int gap;
        req_t r;
        logic [127:0] junk;
        roll = $urandom_range(99);
        gap = roll < 60 ? 0 : (roll < 92 ? $urandom_range(3, 1) : $urandom_range(80, 20));
        r.func = f;
        r.order_id = id;
        r.side = s;
        r.price = p;
        r.quantity = q;
        repeat (gap) @(negedge clk);
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_rsp.push_back(book_apply(r));
        @(negedge clk);
        start <= 1'b0;
        junk = {$urandom, $urandom, $urandom, $urandom};
        req <= junk[$bits(req_t)-1:0];
    endtask

    // sender pause until the block has answered everything
    task automatic drain_book;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // result check: every done cycle must match the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0h at %0t", rsp, $realtime);
            end
            else
            begin
                rsp_t want;
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status || rsp.best_bid !== want.best_bid
                    || rsp.best_ask !== want.best_ask)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d bid %0h/%0h ask %0h/%0h (exp/act)",
                                 want.status, rsp.status, want.best_bid, rsp.best_bid,
                                 want.best_ask, rsp.best_ask);
                end
            end
        end
    end

    // each opcode, the ok, duplicate and unknown statuses and corners of the book
    task automatic test_directed;
        send_event(FN_ADD, 32'd0, 1'b0, 32'd100, 32'd10);
        send_event(FN_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(FN_ADD, 32'd0, 1'b1, 32'd50, 32'd5);              // duplicate id
        send_event(FN_ADD, 32'd2, 1'b1, 32'd120, 32'd7);
        send_event(FN_ADD, 32'd3, 1'b0, 32'd0, 32'd4);               // bid at price zero
        send_event(FN_ADD, 32'd4, 1'b0, 32'd110, 32'd0);             // zero quantity, no level
        send_event(FN_CANCEL, 32'd99, 1'b0, 32'd0, 32'd0);           // unknown ids
        send_event(FN_MODIFY, 32'd99, 1'b0, 32'd0, 32'd3);
        send_event(FN_EXEC, 32'd99, 1'b1, 32'd0, 32'd3);
        send_event(FN_MODIFY, 32'd4, 1'b0, 32'd0, 32'd0);            // shrink on missing level
        send_event(FN_MODIFY, 32'd4, 1'b0, 32'd0, 32'd6);            // raise creates level
        send_event(FN_MODIFY, 32'd0, 1'b0, 32'd0, 32'd20);
        send_event(FN_MODIFY, 32'd0, 1'b0, 32'd0, 32'd0);            // empties level, stays live
        send_event(FN_CANCEL, 32'd0, 1'b0, 32'd0, 32'd0);
        send_event(FN_EXEC, 32'd2, 1'b0, 32'd0, 32'd3);              // partial fill
        send_event(FN_EXEC, 32'd2, 1'b0, 32'd0, 32'hFFFF_FFFF);      // fill beyond remaining
        send_event(FN_EXEC, 32'd2, 1'b0, 32'd0, 32'd1);              // unknown id after the fill
        send_event(FN_ADD, 32'd5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // same level, summed
        send_event(FN_EXEC, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);      // zero fill
        send_event(FN_CANCEL, 32'd3, 1'b0, 32'd0, 32'd0);
        send_event(FN_CANCEL, 32'd4, 1'b0, 32'd0, 32'd0);
    endtask

    // fill the ask ladder to capacity and push one level past it
    task automatic test_level_full;
        for (int i = 0; i < MAX_LEVELS; i++)
            send_event(FN_ADD, 32'h1000_0000 + i, 1'b1, 32'd2000 + 2 * i, $urandom_range(50, 1));
        send_event(FN_ADD, 32'h2000_0000, 1'b1, 32'd2001, 32'd5);     // no room for a level
        send_event(FN_ADD, 32'h2000_0001, 1'b1, 32'd2002, 32'd5);     // existing level is fine
        send_event(FN_ADD, 32'h2000_0002, 1'b1, 32'd2003, 32'd0);     // no level needed
        send_event(FN_MODIFY, 32'h2000_0002, 1'b0, 32'd0, 32'd9);     // raise blocked
        drain_book();
    endtask

    // random events, mostly aimed at live orders and a narrow price band
    task automatic test_random;
        int n_live;
        int pick;
        logic [1:0] f;
        logic [31:0] id;
        logic [31:0] p;
        logic [31:0] q;
        bit s;
        for (int k = 0; k < 150; k++)
        begin
            f = 2'($urandom_range(3));
            s = 1'($urandom_range(1));
            p = $urandom_range(99) < 85 ? 32'($urandom_range(2600, 1900)) : $urandom;
            q = $urandom_range(99) < 80 ? 32'($urandom_range(60)) : $urandom;
            id = $urandom;
            n_live = 0;
            for (int i = 0; i < MAX_ORDERS; i++)
                n_live += book_live[i];
            if (n_live != 0 && (f != FN_ADD || $urandom_range(9) == 0) && $urandom_range(9) < 9)
            begin
                pick = $urandom_range(n_live - 1);
                for (int i = 0; i < MAX_ORDERS; i++)
                    if (book_live[i])
                    begin
                        if (pick == 0)
                        begin
                            id = book_id[i];
                            break;
                        end
                        pick--;
                    end
            end
            send_event(f, id, s, p, q);
            if (k == 75)
                drain_book();
        end
    endtask

    initial
    begin
        mismatches = 0;
        results_seen = 0;
        ladder_n[0] = 0;
        ladder_n[1] = 0;
        for (int i = 0; i < MAX_ORDERS; i++)
            book_live[i] = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_level_full();
        test_random();
        drain_book();
        repeat (2000) @(posedge clk);
        if (pending_rsp.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("price_level_order_book verification clean");
        else
            $display("price_level_order_book verification failed");
        $finish;
    end

    // about 430 events plus the clearing pass, with margin
    initial
    begin
        #20_000_000;
        $display("price_level_order_book verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/plbk_pkg.sv
rtl/plbk_level_cell.sv
rtl/plbk_level_side.sv
rtl/price_level_order_book.sv
verif/tb.sv
